// ===== rtl/bfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdc_pkg
// Shared constants and types for the battery fault debounce classifier.
// ----------------------------------------------------------------------------
package bfdc_pkg;

  localparam int NUM_FAULTS    = 12;
  localparam int CONFIRM_COUNT = 3;
  localparam int CNT_W         = $clog2(CONFIRM_COUNT + 1);

  // Raw-fault queue between classifier and debounce
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_OVER   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_UNDER  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SPREAD = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_OVER   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_UNDER  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOT         = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLD        = 4'd7;

  // Fault bit positions
  localparam int F_CELL_OV  = 0;
  localparam int F_CELL_UV  = 1;
  localparam int F_PACK_OV  = 2;
  localparam int F_PACK_UV  = 3;
  localparam int F_DISCH_OC = 4;
  localparam int F_CHG_OC   = 5;
  localparam int F_SHORT    = 6;
  localparam int F_OT       = 7;
  localparam int F_UT       = 8;
  localparam int F_IMBAL    = 9;
  localparam int F_COMM     = 10;
  localparam int F_WDOG     = 11;

  // Hardware monitor flag positions
  localparam int HW_SCD = 0;
  localparam int HW_OCD = 1;
  localparam int HW_OCC = 2;
  localparam int HW_OV  = 3;
  localparam int HW_UV  = 4;
  localparam int HW_OT  = 5;
  localparam int HW_UT  = 6;

  localparam logic [1:0] SEV_NONE  = 2'd0;
  localparam logic [1:0] SEV_WARN  = 2'd1;
  localparam logic [1:0] SEV_ALERT = 2'd2;
  localparam logic [1:0] SEV_FAULT = 2'd3;

  typedef logic [NUM_FAULTS-1:0] fault_mask_t;

  // One beat of the raw-fault queue, push or pop side
  typedef struct packed {
    logic        valid;
    fault_mask_t raw;
  } raw_beat_t;

endpackage

// ===== rtl/bfdc_front.sv =====
// ----------------------------------------------------------------------------
// bfdc_front
// Limit registers and snapshot classifier: turns one snapshot into a raw
// fault mask in a single pass of parallel compares.
// ----------------------------------------------------------------------------
module bfdc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bfdc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfdc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             cells_ok_i,
  input  logic [15:0]                      cell_high_mv_i,
  input  logic [15:0]                      cell_low_mv_i,
  input  logic [15:0]                      cell_spread_mv_i,
  input  logic [16:0]                      pack_total_mv_i,
  input  logic                             current_ok_i,
  input  logic signed [23:0]               pack_current_ma_i,
  input  logic                             temps_ok_i,
  input  logic signed [17:0]               sensor_temp_a_i,
  input  logic signed [17:0]               sensor_temp_b_i,
  input  logic signed [17:0]               sensor_temp_c_i,
  input  logic [6:0]                       monitor_flags_i,
  output bfdc_pkg::raw_beat_t              push_o
);

  logic [15:0]        cell_over_q, cell_under_q, cell_spread_q;
  logic [16:0]        pack_over_q, pack_under_q;
  logic [47:0]        current_q;
  logic signed [17:0] hot_q, cold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_over_q   <= '0;
      cell_under_q  <= '0;
      cell_spread_q <= '0;
      pack_over_q   <= '0;
      pack_under_q  <= '0;
      current_q     <= '0;
      hot_q         <= '0;
      cold_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bfdc_pkg::REG_CELL_OVER:   cell_over_q   <= cfg_data_i[15:0];
        bfdc_pkg::REG_CELL_UNDER:  cell_under_q  <= cfg_data_i[15:0];
        bfdc_pkg::REG_CELL_SPREAD: cell_spread_q <= cfg_data_i[15:0];
        bfdc_pkg::REG_PACK_OVER:   pack_over_q   <= cfg_data_i[16:0];
        bfdc_pkg::REG_PACK_UNDER:  pack_under_q  <= cfg_data_i[16:0];
        bfdc_pkg::REG_CURRENT:     current_q     <= cfg_data_i[47:0];
        bfdc_pkg::REG_HOT:         hot_q         <= $signed(cfg_data_i[17:0]);
        bfdc_pkg::REG_COLD:        cold_q        <= $signed(cfg_data_i[17:0]);
        default: ;
      endcase
    end
  end

  logic [15:0]        sc_lim, dc_lim, cc_lim;
  logic signed [24:0] cur_ext, sc_ext, dc_ext, cc_neg;
  logic               sc_trip, dc_trip, cc_trip;
  logic               ot_any, ut_any;
  bfdc_pkg::fault_mask_t raw;

  assign sc_lim  = current_q[47:32];
  assign dc_lim  = current_q[31:16];
  assign cc_lim  = current_q[15:0];
  assign cur_ext = 25'(pack_current_ma_i);
  assign sc_ext  = $signed({9'd0, sc_lim});
  assign dc_ext  = $signed({9'd0, dc_lim});
  assign cc_neg  = -$signed({9'd0, cc_lim});

  assign sc_trip = (sc_lim != '0) && (cur_ext > sc_ext);
  assign dc_trip = (dc_lim != '0) && (cur_ext > dc_ext);
  assign cc_trip = (cc_lim != '0) && (cur_ext < cc_neg);

  assign ot_any = (hot_q != '0) && ((sensor_temp_a_i > hot_q) || (sensor_temp_b_i > hot_q) ||
                                    (sensor_temp_c_i > hot_q));
  assign ut_any = (cold_q != '0) && ((sensor_temp_a_i < cold_q) ||
                                     (sensor_temp_b_i < cold_q) ||
                                     (sensor_temp_c_i < cold_q));

  always_comb begin
    raw = '0;
    raw[bfdc_pkg::F_COMM] = !cells_ok_i || !temps_ok_i;
    if (cells_ok_i) begin
      raw[bfdc_pkg::F_CELL_OV] = (cell_over_q != '0) && (cell_high_mv_i > cell_over_q);
      raw[bfdc_pkg::F_CELL_UV] = (cell_under_q != '0) && (cell_low_mv_i < cell_under_q);
      raw[bfdc_pkg::F_IMBAL]   = (cell_spread_q != '0) && (cell_spread_mv_i > cell_spread_q);
      raw[bfdc_pkg::F_PACK_OV] = (pack_over_q != '0) && (pack_total_mv_i > pack_over_q);
      raw[bfdc_pkg::F_PACK_UV] = (pack_under_q != '0) && (pack_total_mv_i < pack_under_q);
    end
    // only the highest-priority current trip counts
    if (current_ok_i) begin
      if (sc_trip) begin
        raw[bfdc_pkg::F_SHORT] = 1'b1;
      end else if (dc_trip) begin
        raw[bfdc_pkg::F_DISCH_OC] = 1'b1;
      end else if (cc_trip) begin
        raw[bfdc_pkg::F_CHG_OC] = 1'b1;
      end
    end
    if (temps_ok_i) begin
      raw[bfdc_pkg::F_OT] = ot_any;
      raw[bfdc_pkg::F_UT] = ut_any;
    end
    // hardware flags bypass the priority
    raw[bfdc_pkg::F_SHORT]    = raw[bfdc_pkg::F_SHORT]    | monitor_flags_i[bfdc_pkg::HW_SCD];
    raw[bfdc_pkg::F_DISCH_OC] = raw[bfdc_pkg::F_DISCH_OC] | monitor_flags_i[bfdc_pkg::HW_OCD];
    raw[bfdc_pkg::F_CHG_OC]   = raw[bfdc_pkg::F_CHG_OC]   | monitor_flags_i[bfdc_pkg::HW_OCC];
    raw[bfdc_pkg::F_CELL_OV]  = raw[bfdc_pkg::F_CELL_OV]  | monitor_flags_i[bfdc_pkg::HW_OV];
    raw[bfdc_pkg::F_CELL_UV]  = raw[bfdc_pkg::F_CELL_UV]  | monitor_flags_i[bfdc_pkg::HW_UV];
    raw[bfdc_pkg::F_OT]       = raw[bfdc_pkg::F_OT]       | monitor_flags_i[bfdc_pkg::HW_OT];
    raw[bfdc_pkg::F_UT]       = raw[bfdc_pkg::F_UT]       | monitor_flags_i[bfdc_pkg::HW_UT];
    raw[bfdc_pkg::F_WDOG]     = 1'b0;
  end

  assign push_o.valid = in_valid_i;
  assign push_o.raw   = raw;

endmodule

// ===== rtl/bfdc_fifo.sv =====
// ----------------------------------------------------------------------------
// bfdc_fifo
// Short queue of raw fault masks between classifier and debounce.
// ----------------------------------------------------------------------------
module bfdc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfdc_pkg::raw_beat_t push_i,
  output logic                push_ready_o,
  output bfdc_pkg::raw_beat_t pop_o,
  input  logic                pop_ready_i
);

  bfdc_pkg::fault_mask_t               mem_q [bfdc_pkg::FIFO_DEPTH];
  logic [bfdc_pkg::PTR_W-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bfdc_pkg::FCNT_W-1:0]         count_q, count_d;
  logic                                do_push, do_pop;

  assign push_ready_o = (count_q != bfdc_pkg::FCNT_W'(bfdc_pkg::FIFO_DEPTH));
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.raw    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_o.valid && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == bfdc_pkg::PTR_W'(bfdc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == bfdc_pkg::PTR_W'(bfdc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.raw;
    end
  end

endmodule

// ===== rtl/bfdc_back.sv =====
// ----------------------------------------------------------------------------
// bfdc_back
// Debounce counters, severity encode and the result register.
// ----------------------------------------------------------------------------
module bfdc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfdc_pkg::raw_beat_t   pop_i,
  output logic                  pop_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bfdc_pkg::fault_mask_t confirmed_faults_o,
  output logic [1:0]            severity_o,
  output logic                  power_off_request_o
);

  localparam logic [bfdc_pkg::CNT_W-1:0] TOP = bfdc_pkg::CNT_W'(bfdc_pkg::CONFIRM_COUNT);

  logic [bfdc_pkg::CNT_W-1:0] cnt_q [bfdc_pkg::NUM_FAULTS];
  logic [bfdc_pkg::CNT_W-1:0] cnt_d [bfdc_pkg::NUM_FAULTS];
  bfdc_pkg::fault_mask_t      conf;
  logic [1:0]                 sev;
  logic                       take;
  logic                       out_valid_q;
  bfdc_pkg::fault_mask_t      conf_q;
  logic [1:0]                 sev_q;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign take        = pop_i.valid && pop_ready_o;

  always_comb begin
    for (int i = 0; i < bfdc_pkg::NUM_FAULTS; i++) begin
      cnt_d[i] = cnt_q[i];
      if (pop_i.raw[i]) begin
        if (cnt_q[i] < TOP) cnt_d[i] = cnt_q[i] + 1'b1;
      end else begin
        if (cnt_q[i] != '0) cnt_d[i] = cnt_q[i] - 1'b1;
      end
      conf[i] = (cnt_d[i] >= TOP);
    end
  end

  always_comb begin
    if (conf[bfdc_pkg::F_SHORT] || conf[bfdc_pkg::F_DISCH_OC]) begin
      sev = bfdc_pkg::SEV_FAULT;
    end else if (conf[bfdc_pkg::F_CELL_OV] || conf[bfdc_pkg::F_CELL_UV] ||
                 conf[bfdc_pkg::F_PACK_OV] || conf[bfdc_pkg::F_PACK_UV] ||
                 conf[bfdc_pkg::F_CHG_OC]) begin
      sev = bfdc_pkg::SEV_ALERT;
    end else if (conf[bfdc_pkg::F_OT] || conf[bfdc_pkg::F_UT] || conf[bfdc_pkg::F_IMBAL]) begin
      sev = bfdc_pkg::SEV_WARN;
    end else begin
      sev = bfdc_pkg::SEV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bfdc_pkg::NUM_FAULTS; i++) begin
        cnt_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < bfdc_pkg::NUM_FAULTS; i++) begin
          cnt_q[i] <= cnt_d[i];
        end
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      conf_q <= conf;
      sev_q  <= sev;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign confirmed_faults_o  = conf_q;
  assign severity_o          = sev_q;
  assign power_off_request_o = (sev_q == bfdc_pkg::SEV_FAULT);

endmodule

// ===== rtl/battery_fault_debounce_classifier.sv =====
// ----------------------------------------------------------------------------
// battery_fault_debounce_classifier
// Pack protection: limit checks on each snapshot, debounced fault mask out.
// ----------------------------------------------------------------------------
// Takes one measurement snapshot per cycle while the queue has room and
// returns one result per snapshot, in order. A snapshot is classified in
// the cycle it is accepted and its raw fault mask enters a two-entry queue;
// the debounce stage pops one mask per cycle unless the output stalls,
// steps the twelve saturating counters and loads the result register, so
// each mask is held in the queue and then in the result register before its
// result is valid. Sustained rate is one snapshot per cycle when the output
// is not stalled, set by the single counter update per pop. Limit registers
// are written through the cfg port (always ready) and should only change
// while no snapshot is in flight. A limit of zero disables its check.
module battery_fault_debounce_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfdc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cells_ok_i,
  input  logic [15:0]                     cell_high_mv_i,
  input  logic [15:0]                     cell_low_mv_i,
  input  logic [15:0]                     cell_spread_mv_i,
  input  logic [16:0]                     pack_total_mv_i,
  input  logic                            current_ok_i,
  input  logic signed [23:0]              pack_current_ma_i,
  input  logic                            temps_ok_i,
  input  logic signed [17:0]              sensor_temp_a_i,
  input  logic signed [17:0]              sensor_temp_b_i,
  input  logic signed [17:0]              sensor_temp_c_i,
  input  logic [6:0]                      monitor_flags_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [11:0]                     confirmed_faults_o,
  output logic [1:0]                      severity_o,
  output logic                            power_off_request_o
);

  bfdc_pkg::raw_beat_t push, pop;
  logic                pop_ready;

  assign cfg_ready_o = 1'b1;

  bfdc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .cells_ok_i        (cells_ok_i),
    .cell_high_mv_i    (cell_high_mv_i),
    .cell_low_mv_i     (cell_low_mv_i),
    .cell_spread_mv_i  (cell_spread_mv_i),
    .pack_total_mv_i   (pack_total_mv_i),
    .current_ok_i      (current_ok_i),
    .pack_current_ma_i (pack_current_ma_i),
    .temps_ok_i        (temps_ok_i),
    .sensor_temp_a_i   (sensor_temp_a_i),
    .sensor_temp_b_i   (sensor_temp_b_i),
    .sensor_temp_c_i   (sensor_temp_c_i),
    .monitor_flags_i   (monitor_flags_i),
    .push_o            (push)
  );

  bfdc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (in_ready_o),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  bfdc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_i               (pop),
    .pop_ready_o         (pop_ready),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .confirmed_faults_o  (confirmed_faults_o),
    .severity_o          (severity_o),
    .power_off_request_o (power_off_request_o)
  );

endmodule

// ===== tb/battery_fault_debounce_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// battery_fault_debounce_classifier_tb
// Self-checking bench for the pack protection limit checks and fault debounce.
// ----------------------------------------------------------------------------
// Snapshots go in over a valid/ready port with random gaps. Results come back
// under random output stalls. A behavioral model in this file keeps its own
// limit registers and debounce counters and predicts each result beat. A
// checker compares every result beat with the oldest prediction. Limit
// registers are only rewritten once all predicted beats have drained. The
// stimulus is a few directed cases followed by random fault episodes under
// several limit settings, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_fault_debounce_classifier_tb;
  import bfdc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     PHASE_ITEMS    = 250;
  localparam longint CUR_MIN        = -64'sd8388608;
  localparam longint CUR_MAX        = 64'sd8388607;
  localparam longint TEMP_MIN       = -64'sd131072;
  localparam longint TEMP_MAX       = 64'sd131071;

  typedef struct packed {
    logic               cells_ok;
    logic [15:0]        cell_high_mv;
    logic [15:0]        cell_low_mv;
    logic [15:0]        cell_spread_mv;
    logic [16:0]        pack_total_mv;
    logic               current_ok;
    logic signed [23:0] pack_current_ma;
    logic               temps_ok;
    logic signed [17:0] sensor_temp_a;
    logic signed [17:0] sensor_temp_b;
    logic signed [17:0] sensor_temp_c;
    logic [6:0]         monitor_flags;
  } snapshot_t;

  typedef struct packed {
    fault_mask_t faults;
    logic [1:0]  severity;
    logic        power_off;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  cells_ok_i;
  logic [15:0]           cell_high_mv_i;
  logic [15:0]           cell_low_mv_i;
  logic [15:0]           cell_spread_mv_i;
  logic [16:0]           pack_total_mv_i;
  logic                  current_ok_i;
  logic signed [23:0]    pack_current_ma_i;
  logic                  temps_ok_i;
  logic signed [17:0]    sensor_temp_a_i;
  logic signed [17:0]    sensor_temp_b_i;
  logic signed [17:0]    sensor_temp_c_i;
  logic [6:0]            monitor_flags_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [11:0]           confirmed_faults_o;
  logic [1:0]            severity_o;
  logic                  power_off_request_o;

  // Shadow of the limit registers and the debounce counters
  logic [15:0]        lim_cell_over   = '0;
  logic [15:0]        lim_cell_under  = '0;
  logic [15:0]        lim_cell_spread = '0;
  logic [16:0]        lim_pack_over   = '0;
  logic [16:0]        lim_pack_under  = '0;
  logic [47:0]        lim_current     = '0;
  logic signed [17:0] lim_hot         = '0;
  logic signed [17:0] lim_cold        = '0;
  int unsigned        debounce_cnt [NUM_FAULTS];

  verdict_t pending_verdicts [$];
  int       errors      = 0;
  int       idle_cycles = 0;
  bit       no_idle     = 1'b0;

  battery_fault_debounce_classifier dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cells_ok_i          (cells_ok_i),
    .cell_high_mv_i      (cell_high_mv_i),
    .cell_low_mv_i       (cell_low_mv_i),
    .cell_spread_mv_i    (cell_spread_mv_i),
    .pack_total_mv_i     (pack_total_mv_i),
    .current_ok_i        (current_ok_i),
    .pack_current_ma_i   (pack_current_ma_i),
    .temps_ok_i          (temps_ok_i),
    .sensor_temp_a_i     (sensor_temp_a_i),
    .sensor_temp_b_i     (sensor_temp_b_i),
    .sensor_temp_c_i     (sensor_temp_c_i),
    .monitor_flags_i     (monitor_flags_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .confirmed_faults_o  (confirmed_faults_o),
    .severity_o          (severity_o),
    .power_off_request_o (power_off_request_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral model
  // --------------------------------------------------------------------------
  function automatic void store_limit(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CELL_OVER:   lim_cell_over   = data[15:0];
      REG_CELL_UNDER:  lim_cell_under  = data[15:0];
      REG_CELL_SPREAD: lim_cell_spread = data[15:0];
      REG_PACK_OVER:   lim_pack_over   = data[16:0];
      REG_PACK_UNDER:  lim_pack_under  = data[16:0];
      REG_CURRENT:     lim_current     = data[47:0];
      REG_HOT:         lim_hot         = data[17:0];
      REG_COLD:        lim_cold        = data[17:0];
      default: ;
    endcase
  endfunction

  function automatic verdict_t classify_and_debounce(input snapshot_t s);
    fault_mask_t raw;
    fault_mask_t conf;
    verdict_t    v;
    longint      cur;
    longint      sc;
    longint      dc;
    longint      cc;
    longint      tv [3];
    raw   = '0;
    conf  = '0;
    cur   = longint'($signed(s.pack_current_ma));
    tv[0] = longint'($signed(s.sensor_temp_a));
    tv[1] = longint'($signed(s.sensor_temp_b));
    tv[2] = longint'($signed(s.sensor_temp_c));
    raw[F_COMM] = !s.cells_ok || !s.temps_ok;
    if (s.cells_ok) begin
      if (lim_cell_over != '0 && s.cell_high_mv > lim_cell_over) raw[F_CELL_OV] = 1'b1;
      if (lim_cell_under != '0 && s.cell_low_mv < lim_cell_under) raw[F_CELL_UV] = 1'b1;
      if (lim_cell_spread != '0 && s.cell_spread_mv > lim_cell_spread) raw[F_IMBAL] = 1'b1;
      if (lim_pack_over != '0 && s.pack_total_mv > lim_pack_over) raw[F_PACK_OV] = 1'b1;
      if (lim_pack_under != '0 && s.pack_total_mv < lim_pack_under) raw[F_PACK_UV] = 1'b1;
    end
    if (s.current_ok) begin
      sc = longint'(lim_current[47:32]);
      dc = longint'(lim_current[31:16]);
      cc = longint'(lim_current[15:0]);
      // only the first current check that trips counts
      if (sc != 0 && cur > sc) begin
        raw[F_SHORT] = 1'b1;
      end else if (dc != 0 && cur > dc) begin
        raw[F_DISCH_OC] = 1'b1;
      end else if (cc != 0 && cur < -cc) begin
        raw[F_CHG_OC] = 1'b1;
      end
    end
    if (s.temps_ok) begin
      for (int i = 0; i < 3; i++) begin
        if (lim_hot != '0 && tv[i] > longint'(lim_hot)) raw[F_OT] = 1'b1;
        if (lim_cold != '0 && tv[i] < longint'(lim_cold)) raw[F_UT] = 1'b1;
      end
    end
    // hardware flags bypass the current priority
    raw[F_SHORT]    = raw[F_SHORT]    | s.monitor_flags[HW_SCD];
    raw[F_DISCH_OC] = raw[F_DISCH_OC] | s.monitor_flags[HW_OCD];
    raw[F_CHG_OC]   = raw[F_CHG_OC]   | s.monitor_flags[HW_OCC];
    raw[F_CELL_OV]  = raw[F_CELL_OV]  | s.monitor_flags[HW_OV];
    raw[F_CELL_UV]  = raw[F_CELL_UV]  | s.monitor_flags[HW_UV];
    raw[F_OT]       = raw[F_OT]       | s.monitor_flags[HW_OT];
    raw[F_UT]       = raw[F_UT]       | s.monitor_flags[HW_UT];
    for (int i = 0; i < NUM_FAULTS; i++) begin
      if (raw[i]) begin
        if (debounce_cnt[i] < CONFIRM_COUNT) debounce_cnt[i] += 1;
      end else if (debounce_cnt[i] > 0) begin
        debounce_cnt[i] -= 1;
      end
      conf[i] = (debounce_cnt[i] >= CONFIRM_COUNT);
    end
    v.faults = conf;
    if (conf[F_SHORT] || conf[F_DISCH_OC]) begin
      v.severity = SEV_FAULT;
    end else if (conf[F_CELL_OV] || conf[F_CELL_UV] || conf[F_PACK_OV] || conf[F_PACK_UV] ||
                 conf[F_CHG_OC]) begin
      v.severity = SEV_ALERT;
    end else if (conf[F_OT] || conf[F_UT] || conf[F_IMBAL]) begin
      v.severity = SEV_WARN;
    end else begin
      v.severity = SEV_NONE;
    end
    v.power_off = (v.severity == SEV_FAULT);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Edge-biased draw in [lo, hi]; an empty range gives hi.
  function automatic longint pick_span(input longint lo, input longint hi);
    if (hi < lo) return hi;
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endcase
  endfunction

  // Draw on the faulting or the passing side of a limit; zero limit is off.
  function automatic longint pick_vs(input longint lim, input longint lo, input longint hi,
                                     input bit over, input bit fault);
    if (lim == 0) return pick_span(lo, hi);
    if (over) return fault ? pick_span(lim + 1, hi) : pick_span(lo, lim);
    return fault ? pick_span(lo, lim - 1) : pick_span(lim, hi);
  endfunction

  function automatic snapshot_t quiet_snapshot();
    snapshot_t s;
    s.cells_ok        = 1'b1;
    s.cell_high_mv    = 16'd3700;
    s.cell_low_mv     = 16'd3650;
    s.cell_spread_mv  = 16'd50;
    s.pack_total_mv   = 17'd11100;
    s.current_ok      = 1'b1;
    s.pack_current_ma = 24'sd1000;
    s.temps_ok        = 1'b1;
    s.sensor_temp_a   = 18'sd25000;
    s.sensor_temp_b   = 18'sd25000;
    s.sensor_temp_c   = 18'sd25000;
    s.monitor_flags   = '0;
    return s;
  endfunction

  function automatic snapshot_t gen_snapshot(input fault_mask_t want);
    snapshot_t    s;
    bit [159:0]   junk;
    longint       tv [3];
    longint       lo;
    longint       hi;
    longint       sc;
    longint       dc;
    longint       cc;
    longint       cur;
    longint       total;
    int unsigned  sel;
    int unsigned  k;
    // some pure noise beats
    if ($urandom_range(0, 7) == 0) begin
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
      s = junk[$bits(snapshot_t)-1:0];
      return s;
    end
    sel = $urandom_range(0, 2);
    s.cells_ok   = !want[F_COMM] || sel == 1;
    s.temps_ok   = !want[F_COMM] || sel == 0;
    s.current_ok = ($urandom_range(0, 15) != 0);
    s.cell_high_mv   = 16'(pick_vs(longint'(lim_cell_over), 0, 65535, 1'b1, want[F_CELL_OV]));
    s.cell_low_mv    = 16'(pick_vs(longint'(lim_cell_under), 0, 65535, 1'b0, want[F_CELL_UV]));
    s.cell_spread_mv = 16'(pick_vs(longint'(lim_cell_spread), 0, 65535, 1'b1, want[F_IMBAL]));
    if (want[F_PACK_OV]) begin
      total = pick_vs(longint'(lim_pack_over), 0, 131071, 1'b1, 1'b1);
    end else if (want[F_PACK_UV]) begin
      total = pick_vs(longint'(lim_pack_under), 0, 131071, 1'b0, 1'b1);
    end else begin
      total = pick_span(longint'(lim_pack_under),
                        lim_pack_over == '0 ? 131071 : longint'(lim_pack_over));
    end
    s.pack_total_mv = 17'(total);
    sc = longint'(lim_current[47:32]);
    dc = longint'(lim_current[31:16]);
    cc = longint'(lim_current[15:0]);
    if (want[F_SHORT]) begin
      cur = pick_vs(sc, CUR_MIN, CUR_MAX, 1'b1, 1'b1);
    end else if (want[F_DISCH_OC]) begin
      cur = pick_span(dc + 1, sc == 0 ? CUR_MAX : sc);
    end else if (want[F_CHG_OC]) begin
      cur = pick_span(CUR_MIN, -cc - 1);
    end else begin
      cur = pick_span(cc == 0 ? CUR_MIN : -cc, dc != 0 ? dc : (sc == 0 ? CUR_MAX : sc));
    end
    s.pack_current_ma = 24'(cur);
    lo = (lim_cold == '0) ? TEMP_MIN : longint'(lim_cold);
    hi = (lim_hot == '0) ? TEMP_MAX : longint'(lim_hot);
    for (int i = 0; i < 3; i++) tv[i] = pick_span(lo, hi);
    if (want[F_OT]) begin
      k = $urandom_range(0, 2);
      tv[k] = pick_vs(longint'(lim_hot), TEMP_MIN, TEMP_MAX, 1'b1, 1'b1);
    end
    if (want[F_UT]) begin
      k = $urandom_range(0, 2);
      tv[k] = pick_vs(longint'(lim_cold), TEMP_MIN, TEMP_MAX, 1'b0, 1'b1);
    end
    s.sensor_temp_a = 18'(tv[0]);
    s.sensor_temp_b = 18'(tv[1]);
    s.sensor_temp_c = 18'(tv[2]);
    s.monitor_flags = '0;
    if ($urandom_range(0, 3) == 0) begin
      s.monitor_flags[HW_SCD] = want[F_SHORT];
      s.monitor_flags[HW_OCD] = want[F_DISCH_OC];
      s.monitor_flags[HW_OCC] = want[F_CHG_OC];
      s.monitor_flags[HW_OV]  = want[F_CELL_OV];
      s.monitor_flags[HW_UV]  = want[F_CELL_UV];
      s.monitor_flags[HW_OT]  = want[F_OT];
      s.monitor_flags[HW_UT]  = want[F_UT];
    end
    if ($urandom_range(0, 15) == 0) begin
      k = $urandom_range(0, 6);
      s.monitor_flags[k] = 1'b1;
    end
    return s;
  endfunction

  function automatic fault_mask_t random_profile();
    fault_mask_t p;
    p = 12'($urandom & $urandom);
    p[F_WDOG] = 1'b0;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_snapshot(input snapshot_t s);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cells_ok_i        <= s.cells_ok;
    cell_high_mv_i    <= s.cell_high_mv;
    cell_low_mv_i     <= s.cell_low_mv;
    cell_spread_mv_i  <= s.cell_spread_mv;
    pack_total_mv_i   <= s.pack_total_mv;
    current_ok_i      <= s.current_ok;
    pack_current_ma_i <= s.pack_current_ma;
    temps_ok_i        <= s.temps_ok;
    sensor_temp_a_i   <= s.sensor_temp_a;
    sensor_temp_b_i   <= s.sensor_temp_b;
    sensor_temp_c_i   <= s.sensor_temp_c;
    monitor_flags_i   <= s.monitor_flags;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_verdicts.push_back(classify_and_debounce(s));
  endtask

  // Hold off input until every predicted beat is out, then let it settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    store_limit(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_limits(input logic [15:0] cell_over, input logic [15:0] cell_under,
                              input logic [15:0] spread, input logic [16:0] pack_over,
                              input logic [16:0] pack_under, input logic [47:0] currents,
                              input logic signed [17:0] hot, input logic signed [17:0] cold);
    write_reg(REG_CELL_OVER, 48'(cell_over));
    write_reg(REG_CELL_UNDER, 48'(cell_under));
    write_reg(REG_CELL_SPREAD, 48'(spread));
    write_reg(REG_PACK_OVER, 48'(pack_over));
    write_reg(REG_PACK_UNDER, 48'(pack_under));
    write_reg(REG_CURRENT, currents);
    write_reg(REG_HOT, 48'(hot));
    write_reg(REG_COLD, 48'(cold));
  endtask

  // Full-width junk data: upper bits must be dropped. One write to an
  // unmapped index that must change nothing.
  task automatic apply_random_limits();
    for (int k = 0; k < 8; k++) begin
      write_reg(CFG_IDX_W'(int'(REG_CELL_OVER) + k), 48'({$urandom, $urandom}));
    end
    write_reg(CFG_IDX_W'(int'(REG_COLD) + int'($urandom_range(1, 8))),
              48'({$urandom, $urandom}));
  endtask

  task automatic apply_typical_limits();
    apply_limits(16'd4200, 16'd2800, 16'd100, 17'd12600, 17'd8400,
                 {16'd30000, 16'd15000, 16'd10000}, 18'sd60000, -18'sd20000);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // All limits are zero after reset: only comm loss may trip.
  task automatic test_disabled_limits();
    snapshot_t s;
    s = quiet_snapshot();
    s.cell_high_mv    = '1;
    s.cell_low_mv     = '0;
    s.cell_spread_mv  = '1;
    s.pack_total_mv   = '1;
    s.pack_current_ma = 24'h7FFFFF;
    s.sensor_temp_a   = 18'h1FFFF;
    s.sensor_temp_b   = 18'h1FFFF;
    s.sensor_temp_c   = 18'h1FFFF;
    send_snapshot(s);
    s.cell_high_mv    = '0;
    s.cell_low_mv     = '1;
    s.cell_spread_mv  = '0;
    s.pack_total_mv   = '0;
    s.pack_current_ma = 24'h800000;
    s.sensor_temp_a   = 18'h20000;
    s.sensor_temp_b   = 18'h20000;
    s.sensor_temp_c   = 18'h20000;
    send_snapshot(s);
    s = quiet_snapshot();
    s.cells_ok = 1'b0;
    s.temps_ok = 1'b0;
    repeat (3) send_snapshot(s);
    s.cells_ok = 1'b1;
    send_snapshot(s);
  endtask

  task automatic test_limit_checks();
    snapshot_t s;
    apply_typical_limits();
    // above both short and discharge limits: short alone trips
    s = quiet_snapshot();
    s.pack_current_ma = 24'h7FFFFF;
    repeat (3) send_snapshot(s);
    s = quiet_snapshot();
    s.pack_current_ma = 24'h800000;
    s.cell_high_mv    = '1;
    s.cell_low_mv     = '0;
    s.cell_spread_mv  = 16'd200;
    s.pack_total_mv   = '0;
    s.sensor_temp_a   = 18'h20000;
    s.sensor_temp_c   = 18'h1FFFF;
    repeat (3) send_snapshot(s);
    // invalid data: checks skipped, comm loss raised
    s.current_ok      = 1'b0;
    s.pack_current_ma = 24'h7FFFFF;
    s.cells_ok        = 1'b0;
    s.temps_ok        = 1'b0;
    send_snapshot(s);
    for (int k = 0; k < 7; k++) begin
      s = quiet_snapshot();
      s.monitor_flags = 7'(1 << k);
      send_snapshot(s);
    end
  endtask

  task automatic test_random_traffic();
    fault_mask_t profile;
    fault_mask_t want;
    int          run_len;
    int          sent;
    int unsigned k;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_typical_limits();
        2: apply_limits('0, '0, '0, '0, '0, '0, '0, '0);
        3: apply_limits('1, '1, '1, '1, '1, '1, 18'h1FFFF, 18'h20000);
        4: apply_limits(16'd1, 16'd1, 16'd1, 17'd1, 17'd1, {16'd1, 16'd1, 16'd1},
                        18'sd1, -18'sd1);
        default: apply_random_limits();
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 3) == 0);
        profile = random_profile();
        run_len = int'($urandom_range(3, 12));
        repeat (run_len) begin
          want = profile;
          if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(0, F_COMM);
            want[k] = !want[k];
          end
          send_snapshot(gen_snapshot(want));
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Sender stops dead until the result side has emptied, twice.
  task automatic test_drain_pause();
    apply_typical_limits();
    repeat (2) begin
      repeat (30) send_snapshot(gen_snapshot(random_profile()));
      drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t oldest;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        errors += 1;
        if (errors <= 10) begin
          $display("unexpected result beat: faults %h severity %0d power_off %0b",
                   confirmed_faults_o, severity_o, power_off_request_o);
        end
      end else begin
        oldest = pending_verdicts.pop_front();
        if (confirmed_faults_o !== oldest.faults || severity_o !== oldest.severity ||
            power_off_request_o !== oldest.power_off) begin
          errors += 1;
          if (errors <= 10) begin
            $display("result mismatch: faults exp %h got %h, severity exp %0d got %0d, %s",
                     oldest.faults, confirmed_faults_o, oldest.severity, severity_o,
                     $sformatf("power_off exp %0b got %0b", oldest.power_off,
                               power_off_request_o));
          end
        end
      end
    end
  end

  // Stall detector: any handshake on any port resets it.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    cells_ok_i        <= 1'b0;
    cell_high_mv_i    <= '0;
    cell_low_mv_i     <= '0;
    cell_spread_mv_i  <= '0;
    pack_total_mv_i   <= '0;
    current_ok_i      <= 1'b0;
    pack_current_ma_i <= '0;
    temps_ok_i        <= 1'b0;
    sensor_temp_a_i   <= '0;
    sensor_temp_b_i   <= '0;
    sensor_temp_c_i   <= '0;
    monitor_flags_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_disabled_limits();
    test_limit_checks();
    test_random_traffic();
    test_drain_pause();
    drain_results();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
